// ===== sv/swmr_pkg.sv =====
// ----------------------------------------------------------------------------
// swmr_pkg
// Shared types, widths and helpers for the sliding-window mean/RMS block.
// ----------------------------------------------------------------------------
`default_nettype none

package swmr_pkg;

    localparam int SMP_W          = 16;
    localparam int WIN_W          = 11;
    localparam int SSUM_W         = 27;
    localparam int DSUM_W         = 43;
    localparam int IDX_W          = 32;
    localparam int SQR_W          = 32;
    localparam int CFG_AW         = 1;
    localparam int DEF_MAX_WINDOW = 1024;

    localparam logic [WIN_W-1:0] WIN_LEN_RESET = 11'd1000;

    typedef enum logic [CFG_AW-1:0] {
        REG_WINDOW_LENGTH  = 1'b0,
        REG_REFERENCE_MEAN = 1'b1
    } t_cfg_reg;

    // One full window handed from the front end to the arithmetic back end
    typedef struct packed {
        logic signed [SSUM_W-1:0] ssum;
        logic [DSUM_W-1:0]        dsum;
        logic [IDX_W-1:0]         centre;
    } t_win_item;

    // Zero counts as one, oversize clamps to the ring depth
    function automatic logic [WIN_W-1:0] f_eff_window(input logic [WIN_W-1:0] len,
                                                      input logic [16:0] maxw);
        logic [WIN_W-1:0] w;
        w = len;
        if (len == '0) begin
            w = {{(WIN_W-1){1'b0}}, 1'b1};
        end
        if (17'(len) > maxw) begin
            w = maxw[WIN_W-1:0];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/swmr_front.sv =====
// ----------------------------------------------------------------------------
// swmr_front
// Sample ring, running sum and running squared-deviation sum.
// ----------------------------------------------------------------------------
`default_nettype none

module swmr_front
    import swmr_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_restart,
    input  wire logic [WIN_W-1:0]        i_win,
    input  wire logic signed [SMP_W-1:0] i_ref_mean,
    input  wire logic                    i_push,
    input  wire logic signed [SMP_W-1:0] i_sample,
    output logic                         o_busy,
    output logic                         o_q_push,
    output t_win_item                    o_q_item,
    input  wire logic                    i_q_full
);

    localparam int AW = $clog2(MAX_WINDOW);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SQ   = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic signed [SMP_W-1:0]  r_mem [MAX_WINDOW];
    logic signed [SMP_W-1:0]  r_x, r_old;
    logic [AW-1:0]            r_pos, r_wpos;
    logic [WIN_W-1:0]         r_fill;
    logic [IDX_W-1:0]         r_wstart;
    logic signed [SSUM_W-1:0] r_ssum;
    logic [DSUM_W-1:0]        r_dsum;
    logic [SQR_W-1:0]         r_sq_new, r_sq_old;
    logic                     r_evict;

    logic                     accept;
    logic [AW-1:0]            pos_eff;
    logic signed [16:0]       d_new, d_old;
    logic [15:0]              m_new, m_old;
    logic [WIN_W-1:0]         fill_n;
    logic                     has_result, upd_done;
    logic [32:0]              centre_sum;
    logic [AW-1:0]            wpos_inc;

    assign accept  = (r_state == S_IDLE) && i_push;
    assign o_busy  = (r_state != S_IDLE);
    assign pos_eff = (32'(r_wpos) >= 32'(i_win)) ? '0 : r_wpos;

    assign d_new = 17'(r_x) - 17'(i_ref_mean);
    assign d_old = 17'(r_old) - 17'(i_ref_mean);
    assign m_new = d_new[16] ? 16'(-d_new) : d_new[15:0];
    assign m_old = d_old[16] ? 16'(-d_old) : d_old[15:0];

    assign fill_n     = r_evict ? r_fill : r_fill + 1'b1;
    assign has_result = (fill_n >= i_win);
    assign upd_done   = (r_state == S_UPD) && !(has_result && i_q_full);
    assign centre_sum = {1'b0, r_wstart} + 33'(i_win[WIN_W-1:1]);
    assign wpos_inc   = r_pos + 1'b1;

    assign o_q_push        = (r_state == S_UPD) && has_result && !i_q_full;
    assign o_q_item.ssum   = r_ssum + SSUM_W'(r_x) - (r_evict ? SSUM_W'(r_old) : '0);
    assign o_q_item.dsum   = r_dsum + DSUM_W'(r_sq_new) - (r_evict ? DSUM_W'(r_sq_old) : '0);
    assign o_q_item.centre = centre_sum[32] ? '1 : centre_sum[31:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_SQ;
            S_SQ:    n_state = S_UPD;
            S_UPD:   if (upd_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ring: read old sample on accept, write new one when the update retires
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old <= r_mem[pos_eff];
        end
        if (upd_done) begin
            r_mem[r_pos] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x     <= i_sample;
            r_pos   <= pos_eff;
            r_evict <= (r_fill >= i_win);
        end
        if (r_state == S_SQ) begin
            r_sq_new <= m_new * m_new;
            r_sq_old <= m_old * m_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_fill   <= '0;
            r_wpos   <= '0;
            r_wstart <= '0;
            r_ssum   <= '0;
            r_dsum   <= '0;
        end else if (upd_done) begin
            r_fill <= fill_n;
            r_ssum <= o_q_item.ssum;
            r_dsum <= o_q_item.dsum;
            r_wpos <= (32'(wpos_inc) >= 32'(i_win) || wpos_inc == '0) ? '0 : wpos_inc;
            if (has_result && r_wstart != '1) begin
                r_wstart <= r_wstart + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/swmr_queue.sv =====
// ----------------------------------------------------------------------------
// swmr_queue
// Two-entry queue of finished windows between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module swmr_queue
    import swmr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_win_item i_item,
    output logic      o_full,
    input  wire logic i_pop,
    output t_win_item o_item,
    output logic      o_empty
);

    t_win_item  r_slot [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

// ===== sv/swmr_back.sv =====
// ----------------------------------------------------------------------------
// swmr_back
// Bit-serial divides by the window, bit-pair square root, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swmr_back
    import swmr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [WIN_W-1:0] i_win,
    input  t_win_item             i_item,
    input  wire logic             i_q_empty,
    output logic                  o_q_pop,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output logic signed [15:0]    o_window_mean,
    output logic [15:0]           o_window_rms,
    output logic [IDX_W-1:0]      o_centre_index
);

    localparam int CNT_W = $clog2(DSUM_W);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIV  = 4'b0010,
        B_SQRT = 4'b0100,
        B_DONE = 4'b1000
    } t_bstate;

    t_bstate           r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [DSUM_W-1:0] r_dnum, r_mnum;
    logic [WIN_W-1:0]  r_drem, r_mrem;
    logic              r_neg;
    logic [IDX_W-1:0]  r_centre;
    logic [SQR_W-1:0]  r_sq_in;
    logic [17:0]       r_srem;
    logic [15:0]       r_root;
    logic              r_out_valid;

    logic [WIN_W:0]    dt, mt;
    logic              dq, mq;
    logic [17:0]       st, strial;
    logic              sq;
    logic [SSUM_W-1:0] mag;
    logic [15:0]       mean_q;
    logic              out_free;

    assign mag      = i_item.ssum[SSUM_W-1] ? SSUM_W'(-i_item.ssum) : i_item.ssum;
    assign o_q_pop  = (r_state == B_IDLE) && !i_q_empty;
    assign out_free = !r_out_valid || i_pop;
    assign o_empty  = !r_out_valid;

    // restoring divide step on both dividends
    assign dt = {r_drem, r_dnum[DSUM_W-1]};
    assign mt = {r_mrem, r_mnum[DSUM_W-1]};
    assign dq = (dt >= (WIN_W+1)'(i_win));
    assign mq = (mt >= (WIN_W+1)'(i_win));

    assign st     = {r_srem[15:0], r_sq_in[SQR_W-1 -: 2]};
    assign strial = {r_root, 2'b01};
    assign sq     = (st >= strial);

    assign mean_q = r_mnum[15:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_q_empty) n_state = B_DIV;
            B_DIV:   if (r_cnt == '0) n_state = B_SQRT;
            B_SQRT:  if (r_cnt == '0) n_state = B_DONE;
            B_DONE:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_dnum   <= i_item.dsum;
                r_mnum   <= DSUM_W'(mag);
                r_neg    <= i_item.ssum[SSUM_W-1];
                r_centre <= i_item.centre;
                r_drem   <= '0;
                r_mrem   <= '0;
                r_cnt    <= CNT_W'(DSUM_W - 1);
            end
            B_DIV: begin
                r_drem <= dq ? WIN_W'(dt - (WIN_W+1)'(i_win)) : dt[WIN_W-1:0];
                r_mrem <= mq ? WIN_W'(mt - (WIN_W+1)'(i_win)) : mt[WIN_W-1:0];
                r_dnum <= {r_dnum[DSUM_W-2:0], dq};
                r_mnum <= {r_mnum[DSUM_W-2:0], mq};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    // mean of squares never reaches 2^32
                    r_sq_in <= r_dnum[SQR_W-2:0] == '0 && !dq ? '0
                             : {r_dnum[SQR_W-2:0], dq};
                    r_srem  <= '0;
                    r_root  <= '0;
                    r_cnt   <= CNT_W'(15);
                end
            end
            B_SQRT: begin
                r_srem  <= sq ? st - strial : st;
                r_root  <= {r_root[14:0], sq};
                r_sq_in <= {r_sq_in[SQR_W-3:0], 2'b00};
                r_cnt   <= r_cnt - 1'b1;
            end
            B_DONE: begin
                if (out_free) begin
                    o_window_mean  <= r_neg ? 16'(-mean_q) : mean_q;
                    o_window_rms   <= r_root;
                    o_centre_index <= r_centre;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/sliding_window_mean_rms_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_mean_rms_top
// Moving mean and moving RMS deviation over a Q8.8 sample stream.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  samples   | push / full        | i_sample
//  results   | empty / pop        | o_window_mean, o_window_rms, o_centre_index
//  config    | i_cfg_we           | i_cfg_addr, i_cfg_data
//
//  Front end takes one sample at a time, in order: ring read, square, sum update;
//  a full queue can hold it in the sum update. Back end takes one window at a time:
//  1 pop, 43 divide steps, 16 root steps, 1 result load, which waits for a free
//  result register.
//  Reset is synchronous; the sample ring needs no clearing.
//  A two-deep queue and the result register let either side stall alone.
`default_nettype none

module sliding_window_mean_rms_top
    import swmr_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire logic signed [SMP_W-1:0]  i_sample,
    output logic                          empty,
    input  wire logic                     pop,
    output logic signed [15:0]            o_window_mean,
    output logic [15:0]                   o_window_rms,
    output logic [IDX_W-1:0]              o_centre_index,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_AW-1:0]        i_cfg_addr,
    input  wire logic [SMP_W-1:0]         i_cfg_data
);

    logic [WIN_W-1:0]        r_win_len;
    logic signed [SMP_W-1:0] r_ref_mean;
    logic [WIN_W-1:0]        win;
    logic                    q_push, q_full, q_pop, q_empty;
    t_win_item               q_in, q_out;

    assign win = f_eff_window(r_win_len, 17'(MAX_WINDOW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len  <= WIN_LEN_RESET;
            r_ref_mean <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_WINDOW_LENGTH:  r_win_len  <= i_cfg_data[WIN_W-1:0];
                REG_REFERENCE_MEAN: r_ref_mean <= i_cfg_data;
                default: ;
            endcase
        end
    end

    swmr_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (i_cfg_we),
        .i_win      (win),
        .i_ref_mean (r_ref_mean),
        .i_push     (push),
        .i_sample   (i_sample),
        .o_busy     (full),
        .o_q_push   (q_push),
        .o_q_item   (q_in),
        .i_q_full   (q_full)
    );

    swmr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    swmr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_win          (win),
        .i_item         (q_out),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_window_mean  (o_window_mean),
        .o_window_rms   (o_window_rms),
        .o_centre_index (o_centre_index)
    );

endmodule

`default_nettype wire

// ===== sv/swmr_checker.sv =====
// ----------------------------------------------------------------------------
// swmr_checker
// Port-level checks for the sliding-window mean/RMS block.
// ----------------------------------------------------------------------------
`default_nettype none

module swmr_checker
    import swmr_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    push,
    input wire logic                    full,
    input wire logic                    empty,
    input wire logic                    pop,
    input wire logic signed [15:0]      o_window_mean,
    input wire logic [15:0]             o_window_rms,
    input wire logic [IDX_W-1:0]        o_centre_index
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("sample side busy after reset");

    // a sample beat keeps the front end busy for the next cycle
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("front end free right after taking a sample");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_window_mean) && $stable(o_window_rms)
                           && $stable(o_centre_index))
        else $error("waiting result changed");

endmodule

bind sliding_window_mean_rms_top swmr_checker u_swmr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_window_mean  (o_window_mean),
    .o_window_rms   (o_window_rms),
    .o_centre_index (o_centre_index)
);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding-window mean/RMS block: random push and
// pop gaps, register changes between phases, and an in-bench predictor whose
// results are compared against every beat popped from the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import swmr_pkg::*;

    typedef struct {
        logic signed [15:0] mean;
        logic [15:0]        rms;
        logic [31:0]        centre;
    } t_window_res;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic signed [SMP_W-1:0]  i_sample = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic signed [15:0]       o_window_mean;
    logic [15:0]              o_window_rms;
    logic [IDX_W-1:0]         o_centre_index;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]        i_cfg_addr = '0;
    logic [SMP_W-1:0]         i_cfg_data = '0;

    sliding_window_mean_rms_top u_top (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // predictor state
    logic signed [15:0] ring_mem [DEF_MAX_WINDOW];
    longint             run_sum;
    longint             sq_dev_sum;
    int unsigned        fill_cnt;
    int unsigned        wr_pos;
    longint             start_idx;
    logic [10:0]        cfg_win;
    logic signed [15:0] cfg_ref;

    t_window_res        win_results_q[$];
    logic signed [15:0] sample_q[$];
    int                 mismatches = 0;
    int                 windows_seen = 0;
    int                 samples_sent = 0;
    int                 phases_run = 0;
    bit                 calm = 1'b0;

    function automatic int unsigned eff_len();
        if (cfg_win == 0) return 1;
        if (cfg_win > DEF_MAX_WINDOW) return DEF_MAX_WINDOW;
        return cfg_win;
    endfunction

    function automatic longint dev_sq(logic signed [15:0] x);
        longint d;
        d = longint'(x) - longint'(cfg_ref);
        return d * d;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 17; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic void restart_model();
        run_sum = 0;
        sq_dev_sum = 0;
        fill_cnt = 0;
        wr_pos = 0;
        start_idx = 0;
    endfunction

    task automatic predict_window(logic signed [15:0] x);
        int unsigned w;
        int unsigned p;
        longint      rt;
        longint      c;
        t_window_res res;
        w = eff_len();
        p = (wr_pos >= w) ? 0 : wr_pos;
        if (fill_cnt >= w) begin
            run_sum -= longint'(ring_mem[p]);
            sq_dev_sum -= dev_sq(ring_mem[p]);
        end else begin
            fill_cnt++;
        end
        ring_mem[p] = x;
        run_sum += longint'(x);
        sq_dev_sum += dev_sq(x);
        wr_pos = (p + 1 >= w) ? 0 : p + 1;
        if (fill_cnt >= w) begin
            rt = root_floor(sq_dev_sum / w);
            if (rt > 65535) rt = 65535;
            c = start_idx + w / 2;
            if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
            if (start_idx != 64'hFFFF_FFFF) start_idx++;
            res.mean = 16'(run_sum / longint'(w));
            res.rms = 16'(rt);
            res.centre = 32'(c);
            win_results_q.push_back(res);
        end
    endtask

    function automatic int draw_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // sample driver
    int push_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_window(i_sample);
                samples_sent++;
            end
            if (!(push && full)) begin
                if (push_gap > 0) begin
                    push_gap--;
                    push <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    i_sample <= sample_q.pop_front();
                    push <= 1'b1;
                    push_gap = draw_gap();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int pop_gap = 0;
    always @(posedge i_clk) begin
        t_window_res e;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                windows_seen++;
                if (win_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: mean=%0d rms=%0d centre=%0d",
                                 o_window_mean, o_window_rms, o_centre_index);
                end else begin
                    e = win_results_q.pop_front();
                    if (e.mean !== o_window_mean || e.rms !== o_window_rms ||
                        e.centre !== o_centre_index) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("beat %0d: exp mean=%0d rms=%0d centre=%0d, got %0d %0d %0d",
                                     windows_seen, e.mean, e.rms, e.centre,
                                     o_window_mean, o_window_rms, o_centre_index);
                    end
                end
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                pop_gap = draw_gap();
            end
        end
    end

    task automatic write_reg(t_cfg_reg r, logic [15:0] d);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= r;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (r == REG_WINDOW_LENGTH) cfg_win = d[10:0];
        else cfg_ref = d;
        restart_model();
    endtask

    // block idle: sender drained, all windows popped, then settle time
    task automatic wait_idle();
        while (sample_q.size() > 0 || push || win_results_q.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [10:0] wl, logic signed [15:0] rf);
        write_reg(REG_WINDOW_LENGTH, {5'b0, wl});
        write_reg(REG_REFERENCE_MEAN, rf);
        phases_run++;
    endtask

    function automatic logic signed [15:0] rand_sample(int extreme_pct);
        if ($urandom_range(0, 99) < extreme_pct)
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return 16'($urandom());
    endfunction

    initial begin
        int rnd_items;
        int n;
        logic [10:0] wl;
        ring_mem = '{default: '0};
        cfg_win = WIN_LEN_RESET;
        cfg_ref = '0;
        restart_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(posedge i_clk);

        // directed: zero window (acts as one), window of one, window of three
        calm = 1'b1;
        run_phase(11'd0, 16'sd0);
        sample_q = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001,
                     16'sh5555, 16'shAAAA};
        wait_idle();
        calm = 1'b0;
        run_phase(11'd1, 16'sh8000);
        sample_q = '{16'sh7FFF, 16'sh8000};
        wait_idle();
        run_phase(11'd3, 16'sh7FFF);
        sample_q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        wait_idle();

        // oversize window saturates to full ring depth, extreme deviations
        run_phase(11'd2047, 16'sh7FFF);
        repeat (1040) sample_q.push_back(rand_sample(60));
        wait_idle();

        // random short windows
        rnd_items = 0;
        while (rnd_items < 380) begin
            wl = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2047))
                                             : 11'($urandom_range(1, 40));
            if (wl > 200) wl = 11'($urandom_range(100, 200));
            calm = ($urandom_range(0, 3) == 0);
            run_phase(wl, 16'($urandom()));
            n = ((wl == 0) ? 1 : (wl > 1024 ? 1024 : wl)) + $urandom_range(10, 90);
            repeat (n) sample_q.push_back(rand_sample(15));
            rnd_items += n;
            wait_idle();
        end
        calm = 1'b0;

        if (win_results_q.size() != 0) mismatches++;
        $display("%0d samples over %0d register settings, %0d windows checked",
                 samples_sent, phases_run, windows_seen);
        $display("windows of 0..200 and oversize; extreme samples and references");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/swmr_pkg.sv
sv/swmr_front.sv
sv/swmr_queue.sv
sv/swmr_back.sv
sv/sliding_window_mean_rms_top.sv
sv/swmr_checker.sv
verif/tb.sv
